>>> src/plb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the price-level book update block.
// No dependencies; every other file of the block but plb_ifs uses this package.
package plb_pkg;

    localparam int NUM_INSTRUMENTS = 4;
    localparam int MAX_LEVELS      = 64;
    localparam int MAX_OUT_LEVELS  = 25;
    localparam int VALUE_BITS      = 48;

    localparam int FIELD_W     = 48;
    localparam int INST_W      = 2;
    localparam int LVL_W       = 5;
    localparam int DEPTH_W     = 5;
    localparam int DEPTH_RESET = 5;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_DEPTH   = 0;

    localparam int INST_IDX_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
    localparam int BOOK_W     = INST_IDX_W + 1;
    localparam int BOOK_CNT   = NUM_INSTRUMENTS * 2;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int POS_W      = $clog2(MAX_LEVELS);
    localparam int OUTN_W     = $clog2(MAX_OUT_LEVELS + 1);

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        t_value price;
        t_value volume;
    } t_level;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_OVW,
        MODE_DEL,
        MODE_INS
    } t_mode;

    typedef struct packed {
        logic              cmp;
        logic              apply;
        t_mode             mode;
        logic [BOOK_W-1:0] book;
        t_value            price;
        t_value            volume;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_HEAD,
        S_CROSS,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [INST_W-1:0] instrument;
        logic              side;
        t_value            price;
        t_value            volume;
        logic              end_of_message;
    } t_request;

    typedef struct packed {
        logic [INST_W-1:0]  instrument_out;
        logic               side_out;
        logic [LVL_W-1:0]   level_index;
        logic [FIELD_W-1:0] level_price;
        logic [FIELD_W-1:0] level_volume;
        logic               crossed;
        logic               overflowed;
        logic               last_result;
    } t_result;

endpackage

>>> src/plb_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for update requests and reported levels.
// Field widths are the fixed widths of the request and result formats.
interface plb_upd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  instrument;
    logic        side;
    logic [47:0] price;
    logic [47:0] volume;
    logic        end_of_message;

    modport source(output valid, instrument, side, price, volume, end_of_message,
                   input ready);
    modport sink(input valid, instrument, side, price, volume, end_of_message,
                 output ready);
endinterface

interface plb_lvl_if;
    logic        valid;
    logic        ready;
    logic [1:0]  instrument_out;
    logic        side_out;
    logic [4:0]  level_index;
    logic [47:0] level_price;
    logic [47:0] level_volume;
    logic        crossed;
    logic        overflowed;
    logic        last_result;

    modport source(output valid, instrument_out, side_out, level_index, level_price,
                   level_volume, crossed, overflowed, last_result, input ready);
    modport sink(input valid, instrument_out, side_out, level_index, level_price,
                 level_volume, crossed, overflowed, last_result, output ready);
endinterface

>>> src/price_level_book_update.sv
`timescale 1ns / 1ps
// An update goes from acceptance through a compare in every cell, then a shift or
// overwrite in every cell, then back to idle; an update that ends a message then checks
// for an empty or crossed book, then reports one level per cycle while
// the output side takes them. The book lives in a row of MAX_LEVELS cells, one per
// rank; updates are taken one at a time. Depends on plb_pkg, plb_ifs and plb_cell.
module price_level_book_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    plb_upd_if.sink                      i_upd,
    plb_lvl_if.source                    o_lvl,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [plb_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [plb_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [plb_pkg::PDATA_W-1:0]  o_prdata,
    output logic                         o_pready
);

    localparam int ML = plb_pkg::MAX_LEVELS;

    plb_pkg::t_state   r_state, n_state;
    plb_pkg::t_request r_req;
    plb_pkg::t_result  r_out, n_out;
    logic              r_ovalid, n_ovalid;

    logic [plb_pkg::CNT_W-1:0]   r_cnt [plb_pkg::BOOK_CNT];
    logic [plb_pkg::NUM_INSTRUMENTS-1:0] r_ovf;
    logic [plb_pkg::DEPTH_W-1:0] r_depth;
    logic [plb_pkg::CNT_W-1:0]   r_nb;
    plb_pkg::t_value             r_bid_px;
    logic                        r_crossed, n_crossed;
    logic [plb_pkg::OUTN_W-1:0]  r_ob, r_oa, n_ob, n_oa;
    logic [plb_pkg::OUTN_W-1:0]  r_idx, n_idx;
    logic                        r_side, n_side;

    plb_pkg::t_cell_ctl          w_ctl;
    plb_pkg::t_mode              w_mode;
    logic [plb_pkg::BOOK_W-1:0]  w_book;
    logic [plb_pkg::INST_IDX_W-1:0] w_inst;
    logic [plb_pkg::CNT_W-1:0]   w_cnt_cur;
    logic                        w_hit;
    logic                        w_load;
    logic                        w_last;
    logic                        w_inst_ok;
    logic                        w_cfg_wr;
    logic [plb_pkg::OUTN_W-1:0]  w_d;

    plb_pkg::t_level w_entry  [ML];
    logic [ML-1:0]   w_before;
    logic [ML-1:0]   w_eq;
    logic [ML-1:0]   w_live;

    assign w_inst    = plb_pkg::INST_IDX_W'(r_req.instrument);
    assign w_cnt_cur = r_cnt[w_book];
    assign w_hit     = |w_eq;
    assign w_inst_ok = (32'(i_upd.instrument) < plb_pkg::NUM_INSTRUMENTS);
    assign w_load    = !r_ovalid || o_lvl.ready;
    assign w_last    = r_crossed || (r_side && (r_idx == r_oa - 1'b1));

    // Cell row: rank k compares its entry against the request, then takes from
    // its left neighbor on insert or from its right neighbor on delete.
    for (genvar k = 0; k < ML; k++) begin : g_cell
        assign w_live[k] = (plb_pkg::CNT_W'(k) < w_cnt_cur);
        plb_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_live        (w_live[k]),
            .i_left_before ((k == 0) ? 1'b1 : w_before[(k == 0) ? 0 : k-1]),
            .i_left        (w_entry[(k == 0) ? 0 : k-1]),
            .i_right       (w_entry[(k == ML-1) ? k : k+1]),
            .o_entry       (w_entry[k]),
            .o_before      (w_before[k]),
            .o_eq          (w_eq[k])
        );
    end

    always_comb begin
        case (r_state)
            plb_pkg::S_HEAD:  w_book = {w_inst, 1'b0};
            plb_pkg::S_CROSS: w_book = {w_inst, 1'b1};
            plb_pkg::S_EMIT:  w_book = {w_inst, r_side};
            default:          w_book = {w_inst, r_req.side};
        endcase
    end

    always_comb begin
        if (w_hit) begin
            w_mode = (r_req.volume != '0) ? plb_pkg::MODE_OVW : plb_pkg::MODE_DEL;
        end else if ((r_req.volume != '0) && (w_cnt_cur < plb_pkg::CNT_W'(ML))) begin
            w_mode = plb_pkg::MODE_INS;
        end else begin
            w_mode = plb_pkg::MODE_NONE;
        end
    end

    always_comb begin
        if (r_depth == '0) begin
            w_d = plb_pkg::OUTN_W'(1);
        end else if (32'(r_depth) > plb_pkg::MAX_OUT_LEVELS) begin
            w_d = plb_pkg::OUTN_W'(plb_pkg::MAX_OUT_LEVELS);
        end else begin
            w_d = plb_pkg::OUTN_W'(r_depth);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            plb_pkg::S_IDLE: begin
                if (i_upd.valid && w_inst_ok) n_state = plb_pkg::S_CMP;
            end
            plb_pkg::S_CMP:   n_state = plb_pkg::S_APPLY;
            plb_pkg::S_APPLY: begin
                n_state = r_req.end_of_message ? plb_pkg::S_HEAD : plb_pkg::S_IDLE;
            end
            plb_pkg::S_HEAD:  n_state = plb_pkg::S_CROSS;
            plb_pkg::S_CROSS: begin
                if ((r_nb == '0) || (w_cnt_cur == '0)) n_state = plb_pkg::S_IDLE;
                else                                   n_state = plb_pkg::S_EMIT;
            end
            plb_pkg::S_EMIT: begin
                if (w_load && w_last) n_state = plb_pkg::S_IDLE;
            end
            default: n_state = plb_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath controls.
    always_comb begin
        w_ctl        = '0;
        w_ctl.book   = w_book;
        w_ctl.price  = r_req.price;
        w_ctl.volume = r_req.volume;
        w_ctl.mode   = w_mode;
        w_ctl.cmp    = 1'b0;
        w_ctl.apply  = 1'b0;
        n_crossed    = r_crossed;
        n_ob         = r_ob;
        n_oa         = r_oa;
        n_idx        = r_idx;
        n_side       = r_side;
        n_out        = r_out;
        n_ovalid     = r_ovalid && !o_lvl.ready;
        case (r_state)
            plb_pkg::S_CMP:   w_ctl.cmp = 1'b1;
            plb_pkg::S_APPLY: w_ctl.apply = 1'b1;
            plb_pkg::S_CROSS: begin
                n_crossed = (w_entry[0].price <= r_bid_px);
                n_ob = (r_nb < plb_pkg::CNT_W'(w_d)) ? plb_pkg::OUTN_W'(r_nb) : w_d;
                n_oa = (w_cnt_cur < plb_pkg::CNT_W'(w_d)) ? plb_pkg::OUTN_W'(w_cnt_cur)
                                                          : w_d;
                n_idx  = '0;
                n_side = 1'b0;
            end
            plb_pkg::S_EMIT: begin
                if (w_load) begin
                    n_ovalid             = 1'b1;
                    n_out.instrument_out = r_req.instrument;
                    n_out.overflowed     = r_ovf[w_inst];
                    n_out.last_result    = w_last;
                    n_out.crossed        = r_crossed;
                    if (r_crossed) begin
                        n_out.side_out     = 1'b0;
                        n_out.level_index  = '0;
                        n_out.level_price  = '0;
                        n_out.level_volume = '0;
                    end else begin
                        n_out.side_out     = r_side;
                        n_out.level_index  = plb_pkg::LVL_W'(r_idx);
                        n_out.level_price  =
                            plb_pkg::FIELD_W'(w_entry[plb_pkg::POS_W'(r_idx)].price);
                        n_out.level_volume =
                            plb_pkg::FIELD_W'(w_entry[plb_pkg::POS_W'(r_idx)].volume);
                    end
                    if (!r_side && (r_idx == r_ob - 1'b1)) begin
                        n_side = 1'b1;
                        n_idx  = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_cfg_wr = i_psel && i_penable && i_pwrite &&
                      (i_paddr[plb_pkg::PADDR_W-1:2] == plb_pkg::REG_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= plb_pkg::S_IDLE;
            r_ovalid  <= 1'b0;
            r_ovf     <= '0;
            r_depth   <= plb_pkg::DEPTH_W'(plb_pkg::DEPTH_RESET);
            r_crossed <= 1'b0;
            r_side    <= 1'b0;
            r_idx     <= '0;
            r_ob      <= '0;
            r_oa      <= '0;
            r_nb      <= '0;
            for (int b = 0; b < plb_pkg::BOOK_CNT; b++) r_cnt[b] <= '0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_crossed <= n_crossed;
            r_side    <= n_side;
            r_idx     <= n_idx;
            r_ob      <= n_ob;
            r_oa      <= n_oa;
            if (w_cfg_wr) r_depth <= i_pwdata[plb_pkg::DEPTH_W-1:0];
            if (r_state == plb_pkg::S_HEAD) r_nb <= w_cnt_cur;
            if (r_state == plb_pkg::S_APPLY) begin
                if (w_mode == plb_pkg::MODE_INS) r_cnt[w_book] <= w_cnt_cur + 1'b1;
                if (w_mode == plb_pkg::MODE_DEL) r_cnt[w_book] <= w_cnt_cur - 1'b1;
                if (!w_hit && (r_req.volume != '0) &&
                    (w_cnt_cur >= plb_pkg::CNT_W'(ML))) begin
                    r_ovf[w_inst] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == plb_pkg::S_HEAD) r_bid_px <= w_entry[0].price;
        if (i_upd.valid && i_upd.ready) begin
            r_req.instrument     <= i_upd.instrument;
            r_req.side           <= i_upd.side;
            r_req.price          <= plb_pkg::VALUE_BITS'(i_upd.price);
            r_req.volume         <= plb_pkg::VALUE_BITS'(i_upd.volume);
            r_req.end_of_message <= i_upd.end_of_message;
        end
    end

    assign i_upd.ready = (r_state == plb_pkg::S_IDLE);

    assign o_lvl.valid          = r_ovalid;
    assign o_lvl.instrument_out = r_out.instrument_out;
    assign o_lvl.side_out       = r_out.side_out;
    assign o_lvl.level_index    = r_out.level_index;
    assign o_lvl.level_price    = r_out.level_price;
    assign o_lvl.level_volume   = r_out.level_volume;
    assign o_lvl.crossed        = r_out.crossed;
    assign o_lvl.overflowed     = r_out.overflowed;
    assign o_lvl.last_result    = r_out.last_result;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[plb_pkg::PADDR_W-1:2] == plb_pkg::REG_DEPTH)
                      ? plb_pkg::PDATA_W'(r_depth) : '0;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_cur <= plb_pkg::CNT_W'(ML))
        else $error("level count above table size");

    a_apply_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plb_pkg::S_APPLY) |=>
        (r_state == plb_pkg::S_IDLE || r_state == plb_pkg::S_HEAD))
        else $error("update apply not followed by idle or report");

    a_cross_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.crossed) |-> r_out.last_result)
        else $error("crossed result not marked last");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.valid && i_upd.ready && w_inst_ok) |=> (r_state == plb_pkg::S_CMP))
        else $error("accepted request did not start a compare");
`endif

endmodule

>>> src/plb_cell.sv
`timescale 1ns / 1ps
// One rank of the sorted level tables: holds that rank for every book.
// Depends on plb_pkg; trades entries with its neighbors on insert and delete.
module plb_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plb_pkg::t_cell_ctl i_ctl,
    input  logic               i_live,
    input  logic               i_left_before,
    input  plb_pkg::t_level    i_left,
    input  plb_pkg::t_level    i_right,
    output plb_pkg::t_level    o_entry,
    output logic               o_before,
    output logic               o_eq
);

    plb_pkg::t_level r_tab [plb_pkg::BOOK_CNT];
    plb_pkg::t_level w_cur;
    plb_pkg::t_level w_new;
    logic            r_before;
    logic            r_eq;
    logic            w_desc;

    assign w_cur    = r_tab[i_ctl.book];
    assign w_desc   = ~i_ctl.book[0];
    assign w_new    = '{price: i_ctl.price, volume: i_ctl.volume};
    assign o_entry  = w_cur;
    assign o_before = r_before;
    assign o_eq     = r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before <= 1'b0;
            r_eq     <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_before <= i_live && (w_desc ? (w_cur.price > i_ctl.price)
                                          : (w_cur.price < i_ctl.price));
            r_eq     <= i_live && (w_cur.price == i_ctl.price);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            case (i_ctl.mode)
                plb_pkg::MODE_OVW: begin
                    if (r_eq) r_tab[i_ctl.book].volume <= i_ctl.volume;
                end
                plb_pkg::MODE_DEL: begin
                    if (!r_before) r_tab[i_ctl.book] <= i_right;
                end
                plb_pkg::MODE_INS: begin
                    if (!r_before) begin
                        r_tab[i_ctl.book] <= i_left_before ? w_new : i_left;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> dv/price_level_book_update_checker.sv
`timescale 1ns / 1ps
// Checker for the price-level book update block: watches both channels and the
// register port, predicts reported levels and compares them. Depends on plb_pkg, plb_ifs.
module price_level_book_update_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    plb_upd_if                           upd,
    plb_lvl_if                           lvl,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [plb_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [plb_pkg::PDATA_W-1:0]  i_pwdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending
);

    plb_pkg::t_value book_price [plb_pkg::NUM_INSTRUMENTS][2][plb_pkg::MAX_LEVELS];
    plb_pkg::t_value book_vol   [plb_pkg::NUM_INSTRUMENTS][2][plb_pkg::MAX_LEVELS];
    int              book_cnt   [plb_pkg::NUM_INSTRUMENTS][2];
    logic            book_ovf   [plb_pkg::NUM_INSTRUMENTS];
    logic [plb_pkg::DEPTH_W-1:0] depth;
    plb_pkg::t_result level_queue[$];

    assign o_pending = level_queue.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic update_book(input int inst, input int sd, input plb_pkg::t_value p,
                               input plb_pkg::t_value v);
        int n;
        int pos;
        n = book_cnt[inst][sd];
        pos = 0;
        while (pos < n) begin
            if (sd == 0 ? (book_price[inst][sd][pos] <= p) : (book_price[inst][sd][pos] >= p))
                break;
            pos++;
        end
        if (pos < n && book_price[inst][sd][pos] == p) begin
            if (v != 0) begin
                book_vol[inst][sd][pos] = v;
            end else begin
                for (int k = pos; k < n - 1; k++) begin
                    book_price[inst][sd][k] = book_price[inst][sd][k+1];
                    book_vol[inst][sd][k]   = book_vol[inst][sd][k+1];
                end
                n--;
            end
        end else if (v != 0) begin
            if (n >= plb_pkg::MAX_LEVELS) begin
                book_ovf[inst] = 1'b1;
            end else begin
                for (int k = n; k > pos; k--) begin
                    book_price[inst][sd][k] = book_price[inst][sd][k-1];
                    book_vol[inst][sd][k]   = book_vol[inst][sd][k-1];
                end
                book_price[inst][sd][pos] = p;
                book_vol[inst][sd][pos]   = v;
                n++;
            end
        end
        book_cnt[inst][sd] = n;
    endtask

    task automatic predict_levels(input int inst);
        int d;
        int ob;
        int oa;
        plb_pkg::t_result r;
        if (book_cnt[inst][0] == 0 || book_cnt[inst][1] == 0) return;
        r = '0;
        r.instrument_out = plb_pkg::INST_W'(inst);
        r.overflowed = book_ovf[inst];
        if (book_price[inst][1][0] <= book_price[inst][0][0]) begin
            r.crossed = 1'b1;
            r.last_result = 1'b1;
            level_queue.push_back(r);
            return;
        end
        d = depth;
        if (d < 1) d = 1;
        if (d > plb_pkg::MAX_OUT_LEVELS) d = plb_pkg::MAX_OUT_LEVELS;
        ob = book_cnt[inst][0] < d ? book_cnt[inst][0] : d;
        oa = book_cnt[inst][1] < d ? book_cnt[inst][1] : d;
        for (int sd = 0; sd < 2; sd++) begin
            for (int i = 0; i < (sd == 0 ? ob : oa); i++) begin
                r.side_out = 1'(sd);
                r.level_index = plb_pkg::LVL_W'(i);
                r.level_price = book_price[inst][sd][i];
                r.level_volume = book_vol[inst][sd][i];
                r.last_result = (sd == 1 && i + 1 == oa);
                level_queue.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin
        plb_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < plb_pkg::NUM_INSTRUMENTS; i++) begin
                book_cnt[i][0] = 0;
                book_cnt[i][1] = 0;
                book_ovf[i] = 1'b0;
            end
            depth = plb_pkg::DEPTH_W'(plb_pkg::DEPTH_RESET);
            level_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == plb_pkg::PADDR_W'(4 * plb_pkg::REG_DEPTH))
                depth = i_pwdata[plb_pkg::DEPTH_W-1:0];
            if (lvl.valid && lvl.ready) begin
                if (level_queue.size() == 0) begin
                    report("unexpected level result", 64'd1, 64'd0);
                end else begin
                    want = level_queue.pop_front();
                    if (lvl.instrument_out != want.instrument_out)
                        report("instrument_out", lvl.instrument_out, want.instrument_out);
                    if (lvl.side_out != want.side_out)
                        report("side_out", lvl.side_out, want.side_out);
                    if (lvl.level_index != want.level_index)
                        report("level_index", lvl.level_index, want.level_index);
                    if (lvl.level_price != want.level_price)
                        report("level_price", lvl.level_price, want.level_price);
                    if (lvl.level_volume != want.level_volume)
                        report("level_volume", lvl.level_volume, want.level_volume);
                    if (lvl.crossed != want.crossed)
                        report("crossed", lvl.crossed, want.crossed);
                    if (lvl.overflowed != want.overflowed)
                        report("overflowed", lvl.overflowed, want.overflowed);
                    if (lvl.last_result != want.last_result)
                        report("last_result", lvl.last_result, want.last_result);
                end
            end
            if (upd.valid && upd.ready) begin
                update_book(int'(upd.instrument), int'(upd.side), upd.price, upd.volume);
                if (upd.end_of_message) predict_levels(int'(upd.instrument));
            end
        end
    end

endmodule

>>> dv/price_level_book_update_test.sv
`timescale 1ns / 1ps
// Top of the price-level book update test: clock, reset, register writes and
// update requests with random gaps. Depends on plb_pkg, plb_ifs, the block and its checker.
module price_level_book_update_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_psel = 1'b0;
    logic                        i_penable = 1'b0;
    logic                        i_pwrite = 1'b0;
    logic [plb_pkg::PADDR_W-1:0] i_paddr = '0;
    logic [plb_pkg::PDATA_W-1:0] i_pwdata = '0;
    logic [plb_pkg::PDATA_W-1:0] o_prdata;
    logic                        o_pready;
    int                          fail_count;
    int                          pending;
    int                          cycles = 0;
    bit                          sender_idles = 1'b1;
    bit                          receiver_idles = 1'b1;
    bit                          hold_request = 1'b0;
    bit                          hold_done = 1'b0;

    plb_upd_if upd_if();
    plb_lvl_if lvl_if();

    price_level_book_update uut (
        .i_clk, .i_rst_n, .i_upd(upd_if), .o_lvl(lvl_if),
        .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata, .o_prdata, .o_pready
    );

    price_level_book_update_checker book_checker (
        .i_clk, .i_rst_n, .upd(upd_if), .lvl(lvl_if),
        .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata, .i_pready(o_pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always begin
        int w;
        @(negedge i_clk);
        if (i_rst_n) begin
            w = receiver_idles ? $urandom_range(0, 8) : 0;
            if (hold_request && !hold_done) begin
                w = 400;
                hold_done = 1'b1;
            end
            if (w > 0) begin
                lvl_if.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            lvl_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(lvl_if.valid && lvl_if.ready));
        end else begin
            lvl_if.ready <= 1'b0;
        end
    end

    task automatic send_update(input int inst, input int sd, input logic [47:0] p,
                               input logic [47:0] v, input int eom);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            upd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        upd_if.valid <= 1'b1;
        upd_if.instrument <= plb_pkg::INST_W'(inst);
        upd_if.side <= 1'(sd);
        upd_if.price <= p;
        upd_if.volume <= v;
        upd_if.end_of_message <= 1'(eom);
        do @(posedge i_clk); while (!upd_if.ready);
        @(negedge i_clk);
    endtask

    task automatic write_depth(input logic [plb_pkg::PDATA_W-1:0] value);
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_paddr <= plb_pkg::PADDR_W'(4 * plb_pkg::REG_DEPTH);
        i_pwdata <= value;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
    endtask

    task automatic drain;
        upd_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [47:0] random_value();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic random_phase(input int count);
        int inst;
        int sd;
        logic [47:0] p;
        logic [47:0] v;
        for (int n = 0; n < count; n++) begin
            inst = $urandom_range(0, plb_pkg::NUM_INSTRUMENTS - 1);
            sd = $urandom_range(0, 1);
            v = ($urandom_range(0, 4) == 0) ? 48'd0 : random_value();
            if ($urandom_range(0, 9) == 0) begin
                p = random_value();
                send_update(inst, sd, p, v, int'($urandom_range(0, 2) == 0));
                if ($urandom_range(0, 9) < 8)
                    send_update(inst, sd, p, 48'd0, $urandom_range(0, 1));
            end else begin
                p = ((sd != 0) ? 48'd2000 : 48'd1000) + 48'($urandom_range(0, 39));
                send_update(inst, sd, p, v, int'($urandom_range(0, 2) == 0));
            end
        end
    endtask

    initial begin
        upd_if.valid = 1'b0;
        upd_if.instrument = '0;
        upd_if.side = 1'b0;
        upd_if.price = '0;
        upd_if.volume = '0;
        upd_if.end_of_message = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_update(0, 0, 48'd100, ALL_ONES, 1);
        send_update(0, 1, 48'd200, 48'd1, 1);
        send_update(0, 0, ALL_ONES, 48'd5, 1);
        send_update(0, 0, ALL_ONES, 48'd0, 1);
        send_update(0, 1, 48'd100, 48'd7, 1);
        send_update(0, 1, 48'd100, 48'd0, 0);
        send_update(0, 1, 48'd555, 48'd0, 1);
        send_update(0, 0, 48'd100, 48'd9, 1);
        send_update(1, 1, 48'd0, 48'd3, 1);
        send_update(1, 0, 48'd0, 48'd4, 1);
        send_update(1, 1, 48'd0, 48'd0, 1);
        send_update(1, 1, ALL_ONES, ALL_ONES, 1);
        send_update(2, 1, 48'd50, 48'd2, 0);
        send_update(2, 0, 48'd40, 48'd2, 0);
        send_update(2, 0, 48'd45, 48'd6, 1);
        drain();

        write_depth(25);
        for (int i = 0; i < plb_pkg::MAX_LEVELS + 2; i++)
            send_update(3, 0, 48'd10 + 48'(i), 48'd1 + 48'(i), 0);
        send_update(3, 0, 48'd20, 48'd77, 0);
        send_update(3, 1, 48'd900, 48'd8, 1);
        drain();

        write_depth(0);
        random_phase(40);
        drain();
        write_depth(31);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        random_phase(35);
        drain();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        write_depth(1);
        random_phase(40);
        drain();
        write_depth(25);
        hold_request = 1'b1;
        sender_idles = 1'b0;
        random_phase(50);
        sender_idles = 1'b1;
        drain();
        write_depth($urandom_range(2, 24));
        random_phase(45);
        drain();
        write_depth(5);
        random_phase(45);
        drain();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
src/plb_pkg.sv
src/plb_ifs.sv
src/plb_cell.sv
src/price_level_book_update.sv
dv/price_level_book_update_checker.sv
dv/price_level_book_update_test.sv
